// ----- hw/rtl/ffba_pkg.sv -----
// Shared definitions for the first-fit block allocator: field widths, request
// and status codes, default sizes and the run tracker control structure.
// No dependencies.
package ffba_pkg;

    localparam int CELLS_DEF      = 1024;
    localparam int MAX_BLOCKS_DEF = 128;

    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 11;
    localparam int TARGET_W = 7;
    localparam int STATUS_W = 3;
    localparam int GBLOCK_W = 7;
    localparam int GSTART_W = 10;
    localparam int CAP_W    = 11;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [ACTION_W-1:0] ACT_PUT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_PUT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_GET_OK     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ARRANGE_OK = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_PUT_FAIL   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_GET_FAIL   = 3'd4;

    typedef struct packed {
        logic clear;
        logic step;
        logic busy;
    } run_ctl_t;

endpackage

// ----- hw/rtl/ffba_run_tracker.sv -----
// Free-run tracker for the bitmap scan: counts consecutive free cells and
// flags the first run that reaches the requested length. Depends on ffba_pkg.
module ffba_run_tracker
    import ffba_pkg::*;
#(
    parameter int LEN_W = $clog2(CELLS_DEF) + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  run_ctl_t         ctl,
    input  logic [LEN_W-1:0] cell_idx,
    input  logic [LEN_W-1:0] need,
    output logic             hit,
    output logic [LEN_W-1:0] run_start
);

    logic [LEN_W-1:0] run_len_reg;
    logic [LEN_W-1:0] run_len_next;
    logic [LEN_W-1:0] run_start_reg;
    logic [LEN_W-1:0] run_start_next;

    always_comb
    begin
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        if (ctl.clear)
        begin
            run_len_next   = '0;
            run_start_next = '0;
        end
        else if (ctl.step)
        begin
            if (ctl.busy)
            begin
                run_len_next   = '0;
                run_start_next = cell_idx + LEN_W'(1);
            end
            else
            begin
                run_len_next = run_len_reg + LEN_W'(1);
            end
        end
    end

    assign hit       = ctl.step && !ctl.busy && ((run_len_reg + LEN_W'(1)) == need);
    assign run_start = run_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg   <= '0;
            run_start_reg <= '0;
        end
        else
        begin
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
        end
    end

endmodule

// ----- hw/rtl/first_fit_block_allocator.sv -----
// A put scans for the first free run that fits and fills it, a get frees a block's
// run, an arrange repacks the issued ids and sweeps the bitmap; one request is in
// work at a time. The cell bitmap memory is read or written one cell per cycle.
// After reset the bitmap is cleared in a pass over all CELLS cells before the first
// request transaction is taken; configuration writes are taken at any time.
// Top level of the first-fit block allocator. Depends on ffba_pkg, ffba_run_tracker.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int CELLS      = CELLS_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_W-1:0]    cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // From bit 0: action[1:0], request_size[12:2], target_block[19:13], zero pad.
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // From bit 0: status[2:0], granted_block[9:3], granted_start[19:10], zero pad.
    output logic [M_DATA_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(CELLS);
    localparam int LW = CW + 1;
    localparam int BW = $clog2(MAX_BLOCKS);
    localparam int IW = BW + 1;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_SCAN      = 4'd2;
    localparam logic [3:0] S_FILL      = 4'd3;
    localparam logic [3:0] S_GET_RD    = 4'd4;
    localparam logic [3:0] S_GET_CHK   = 4'd5;
    localparam logic [3:0] S_ARR_RD    = 4'd6;
    localparam logic [3:0] S_ARR_UPD   = 4'd7;
    localparam logic [3:0] S_ARR_SWEEP = 4'd8;
    localparam logic [3:0] S_RESP      = 4'd9;

    typedef struct packed {
        logic          live;
        logic [CW-1:0] start;
        logic [LW-1:0] len;
    } tbl_entry_t;

    logic                cell_mem [CELLS];
    tbl_entry_t          tbl_mem [MAX_BLOCKS];

    logic [3:0]          state_reg, state_next;
    logic [CAP_W-1:0]    capacity_reg, capacity_next;
    logic [IW-1:0]       next_block_reg, next_block_next;
    logic [LW-1:0]       issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [LW-1:0]       chk_reg, chk_next;
    logic [LW-1:0]       size_reg, size_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [CW-1:0]       fill_addr_reg, fill_addr_next;
    logic [LW-1:0]       fill_cnt_reg, fill_cnt_next;
    logic                fill_val_reg, fill_val_next;
    logic [IW-1:0]       arr_id_reg, arr_id_next;
    logic [LW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       sweep_reg, sweep_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [GBLOCK_W-1:0] res_block_reg, res_block_next;
    logic [GSTART_W-1:0] res_start_reg, res_start_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                cell_rd_reg;
    tbl_entry_t          tbl_rd_reg;

    logic                cell_we;
    logic [CW-1:0]       cell_waddr;
    logic                cell_wdata;
    logic [CW-1:0]       cell_raddr;
    logic                tbl_we;
    logic [BW-1:0]       tbl_waddr;
    tbl_entry_t          tbl_wdata;
    logic [BW-1:0]       tbl_raddr;

    logic [ACTION_W-1:0] in_action;
    logic [SIZE_W-1:0]   in_size;
    logic [TARGET_W-1:0] in_target;
    logic                s_accept;
    logic [LW-1:0]       cap_eff;
    logic                issuing;
    logic                out_load;

    run_ctl_t            run_ctl;
    logic                run_hit;
    logic [LW-1:0]       run_start;

    assign in_action = s_axis_tdata[1:0];
    assign in_size   = s_axis_tdata[12:2];
    assign in_target = s_axis_tdata[19:13];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign cap_eff = (int'(capacity_reg) > CELLS) ? LW'(CELLS) : LW'(capacity_reg);
    assign issuing = (issue_reg < cap_eff);

    assign cell_raddr = CW'(issue_reg);
    assign tbl_raddr  = (state_reg == S_ARR_RD) ? BW'(arr_id_reg) : BW'(target_reg);

    ffba_run_tracker #(
        .LEN_W (LW)
    ) u_run_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (run_ctl),
        .cell_idx  (chk_reg),
        .need      (size_reg),
        .hit       (run_hit),
        .run_start (run_start)
    );

    always_comb
    begin
        state_next      = state_reg;
        capacity_next   = capacity_reg;
        next_block_next = next_block_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        chk_next        = chk_reg;
        size_next       = size_reg;
        target_next     = target_reg;
        fill_addr_next  = fill_addr_reg;
        fill_cnt_next   = fill_cnt_reg;
        fill_val_next   = fill_val_reg;
        arr_id_next     = arr_id_reg;
        pos_next        = pos_reg;
        sweep_next      = sweep_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_start_next  = res_start_reg;
        cell_we         = 1'b0;
        cell_waddr      = fill_addr_reg;
        cell_wdata      = fill_val_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = BW'(next_block_reg);
        tbl_wdata       = '0;
        run_ctl         = '0;
        out_load        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = sweep_reg;
                cell_wdata = 1'b0;
                sweep_next = sweep_reg + CW'(1);
                if (sweep_reg == CW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_accept)
                begin
                    res_block_next = '0;
                    res_start_next = '0;
                    case (in_action)
                        ACT_PUT:
                        begin
                            size_next = LW'(in_size);
                            if ((in_size == '0) || (int'(in_size) > int'(cap_eff)) ||
                                (int'(next_block_reg) >= MAX_BLOCKS))
                            begin
                                res_status_next = STAT_PUT_FAIL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                issue_next    = '0;
                                run_ctl.clear = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end

                        ACT_GET:
                        begin
                            target_next = in_target;
                            if ((in_target != '0) && (int'(in_target) < int'(next_block_reg)))
                            begin
                                state_next = S_GET_RD;
                            end
                            else
                            begin
                                res_status_next = STAT_GET_FAIL;
                                state_next      = S_RESP;
                            end
                        end

                        default:
                        begin
                            res_status_next = STAT_ARRANGE_OK;
                            arr_id_next     = IW'(1);
                            pos_next        = '0;
                            sweep_next      = '0;
                            if (next_block_reg == IW'(1))
                            begin
                                state_next = S_ARR_SWEEP;
                            end
                            else
                            begin
                                state_next = S_ARR_RD;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                pend_next    = issuing;
                chk_next     = issue_reg;
                if (issuing)
                begin
                    issue_next = issue_reg + LW'(1);
                end
                run_ctl.step = pend_reg;
                run_ctl.busy = cell_rd_reg;
                if (run_hit)
                begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = BW'(next_block_reg);
                    tbl_wdata.live  = 1'b1;
                    tbl_wdata.start = CW'(run_start);
                    tbl_wdata.len   = size_reg;
                    res_status_next = STAT_PUT_OK;
                    res_block_next  = GBLOCK_W'(next_block_reg);
                    res_start_next  = GSTART_W'(run_start);
                    next_block_next = next_block_reg + IW'(1);
                    fill_addr_next  = CW'(run_start);
                    fill_cnt_next   = size_reg;
                    fill_val_next   = 1'b1;
                    state_next      = S_FILL;
                end
                else if (!pend_reg && !issuing)
                begin
                    res_status_next = STAT_PUT_FAIL;
                    state_next      = S_RESP;
                end
            end

            S_FILL:
            begin
                cell_we        = 1'b1;
                fill_addr_next = fill_addr_reg + CW'(1);
                fill_cnt_next  = fill_cnt_reg - LW'(1);
                if (fill_cnt_reg == LW'(1))
                begin
                    state_next = S_RESP;
                end
            end

            S_GET_RD:
            begin
                state_next = S_GET_CHK;
            end

            S_GET_CHK:
            begin
                if (tbl_rd_reg.live)
                begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = BW'(target_reg);
                    tbl_wdata       = tbl_rd_reg;
                    tbl_wdata.live  = 1'b0;
                    fill_addr_next  = tbl_rd_reg.start;
                    fill_cnt_next   = tbl_rd_reg.len;
                    fill_val_next   = 1'b0;
                    res_status_next = STAT_GET_OK;
                    state_next      = S_FILL;
                end
                else
                begin
                    res_status_next = STAT_GET_FAIL;
                    state_next      = S_RESP;
                end
            end

            S_ARR_RD:
            begin
                state_next = S_ARR_UPD;
            end

            S_ARR_UPD:
            begin
                if (tbl_rd_reg.live)
                begin
                    tbl_we          = 1'b1;
                    tbl_waddr       = BW'(arr_id_reg);
                    tbl_wdata       = tbl_rd_reg;
                    tbl_wdata.start = CW'(pos_reg);
                    pos_next        = pos_reg + tbl_rd_reg.len;
                end
                arr_id_next = arr_id_reg + IW'(1);
                if ((arr_id_reg + IW'(1)) == next_block_reg)
                begin
                    sweep_next = '0;
                    state_next = S_ARR_SWEEP;
                end
                else
                begin
                    state_next = S_ARR_RD;
                end
            end

            S_ARR_SWEEP:
            begin
                cell_we    = 1'b1;
                cell_waddr = sweep_reg;
                cell_wdata = (int'(sweep_reg) < int'(pos_reg));
                sweep_next = sweep_reg + CW'(1);
                if (sweep_reg == CW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, res_start_reg, res_block_reg, res_status_reg};
        end
        else
        begin
            m_valid_next = m_valid_reg && !m_axis_tready;
            m_data_next  = m_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        cell_rd_reg <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            capacity_reg   <= CAP_RESET;
            next_block_reg <= IW'(1);
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            chk_reg        <= '0;
            size_reg       <= '0;
            target_reg     <= '0;
            fill_addr_reg  <= '0;
            fill_cnt_reg   <= '0;
            fill_val_reg   <= 1'b0;
            arr_id_reg     <= '0;
            pos_reg        <= '0;
            sweep_reg      <= '0;
            res_status_reg <= STAT_PUT_FAIL;
            res_block_reg  <= '0;
            res_start_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            capacity_reg   <= capacity_next;
            next_block_reg <= next_block_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            chk_reg        <= chk_next;
            size_reg       <= size_next;
            target_reg     <= target_next;
            fill_addr_reg  <= fill_addr_next;
            fill_cnt_reg   <= fill_cnt_next;
            fill_val_reg   <= fill_val_next;
            arr_id_reg     <= arr_id_next;
            pos_reg        <= pos_next;
            sweep_reg      <= sweep_next;
            res_status_reg <= res_status_next;
            res_block_reg  <= res_block_next;
            res_start_reg  <= res_start_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    // A request transaction closes the input until its result is staged.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("input still ready after a request transaction");

    // The id counter stays within the id space.
    a_next_block_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_block_reg != '0) && (int'(next_block_reg) <= MAX_BLOCKS))
        else $error("next block id out of range");

    // A placed run lies wholly inside the usable capacity.
    a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && run_hit |->
            (int'(run_start) + int'(size_reg) <= int'(cap_eff)))
        else $error("placed run exceeds capacity");

    // A successful put reports the id that was just consumed.
    a_put_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (res_status_reg == STAT_PUT_OK) |->
            (res_block_reg == GBLOCK_W'(next_block_reg - IW'(1))))
        else $error("granted id does not match the id counter");

endmodule
